// ===== design/evr_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Euler vector rotator.
package evr_pkg;

  localparam int COORD_WIDTH        = 16;
  localparam int COEF_FRACTION_BITS = 16;
  localparam int ANGLE_W            = 16;
  localparam int COEF_W             = COEF_FRACTION_BITS + 2;
  localparam int OUT_W              = COORD_WIDTH + 1;
  localparam int PROD_W             = COEF_W + COORD_WIDTH;
  localparam int ACC_W              = PROD_W + 2;
  localparam int QW                 = ACC_W - COEF_FRACTION_BITS;
  localparam int QMUL_W             = 2 * COEF_W;
  localparam int CFG_ADDR_W         = 4;
  localparam int CFG_DATA_W         = 32;
  localparam int NUM_COEF           = 9;
  localparam int NUM_TRIG           = 6;
  localparam int NUM_PROD           = 14;

  // Polynomial evaluation in unsigned Q1.30.
  localparam int U_W     = 30;
  localparam int POLY_W  = 31;
  localparam int MUL_W   = U_W + POLY_W;
  localparam int TRIG_SH = 30 - COEF_FRACTION_BITS;
  localparam int QUARTER = 16384;

  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [OUT_W-1:0]       out_t;
  typedef logic [ANGLE_W-1:0]            angle_t;

  localparam coef_t COEF_ONE = COEF_W'(64'd1 << COEF_FRACTION_BITS);
  localparam logic [POLY_W+1:0] ONE_U = (POLY_W+2)'(64'd1 << COEF_FRACTION_BITS);
  localparam logic [POLY_W+1:0] TRIG_HALF =
    (TRIG_SH > 0) ? (POLY_W+2)'(64'd1 << (TRIG_SH - 1)) : '0;

  localparam logic signed [ACC_W-1:0]  ACC_HALF  = ACC_W'(64'd1 << (COEF_FRACTION_BITS - 1));
  localparam logic signed [QMUL_W-1:0] QMUL_HALF = QMUL_W'(64'd1 << (COEF_FRACTION_BITS - 1));
  localparam logic signed [QW-1:0]     OUT_MAX_Q = QW'((64'd1 << COORD_WIDTH) - 64'd1);
  localparam logic signed [QW-1:0]     OUT_MIN_Q = ~OUT_MAX_Q;

  typedef enum logic [1:0] {
    REG_YAW   = 2'd0,
    REG_PITCH = 2'd1,
    REG_ROLL  = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    TRIG_IDLE,
    TRIG_POLY,
    TRIG_PROD,
    TRIG_COMBINE
  } trig_state_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } lane_ctl_t;

  // Odd polynomial for sin(pi/2 * u), unsigned Q1.30.
  function automatic logic [POLY_W-1:0] poly_coef(input logic [2:0] k);
    logic [POLY_W-1:0] c;
    unique case (k)
      3'd0:    c = POLY_W'(1686629713);
      3'd1:    c = POLY_W'(693598668);
      3'd2:    c = POLY_W'(85569306);
      3'd3:    c = POLY_W'(5026995);
      3'd4:    c = POLY_W'(172272);
      3'd5:    c = POLY_W'(3864);
      3'd6:    c = POLY_W'(61);
      default: c = '0;
    endcase
    return c;
  endfunction

  // Fixed-point product with rounding half away from zero.
  function automatic coef_t qmul(input coef_t a, input coef_t b);
    logic signed [QMUL_W-1:0] p;
    logic signed [QMUL_W-1:0] t;
    p = QMUL_W'(a) * QMUL_W'(b);
    t = p + QMUL_HALF - QMUL_W'({1'b0, p[QMUL_W-1]});
    return t[COEF_FRACTION_BITS+COEF_W-1:COEF_FRACTION_BITS];
  endfunction

  // Limit a coefficient sum to [-1.0, +1.0].
  function automatic coef_t clamp_coef(input logic signed [COEF_W:0] v);
    coef_t c;
    if (v > (COEF_W+1)'(COEF_ONE)) begin
      c = COEF_ONE;
    end else if (v < -(COEF_W+1)'(COEF_ONE)) begin
      c = -COEF_ONE;
    end else begin
      c = v[COEF_W-1:0];
    end
    return c;
  endfunction

endpackage

// ===== design/evr_if.sv =====
// Valid/ready stream interfaces for input points and rotated results.
interface evr_point_if;
  logic            valid;
  logic            ready;
  evr_pkg::coord_t point_x;
  evr_pkg::coord_t point_y;
  evr_pkg::coord_t point_z;

  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface evr_rot_if;
  logic          valid;
  logic          ready;
  evr_pkg::out_t rotated_x;
  evr_pkg::out_t rotated_y;
  evr_pkg::out_t rotated_z;

  modport source (output valid, output rotated_x, output rotated_y, output rotated_z,
                  input ready);
  modport sink   (input valid, input rotated_x, input rotated_y, input rotated_z,
                  output ready);
endinterface

// ===== design/evr_trig_unit.sv =====
// Sequential sine/cosine and rotation matrix builder on shared multipliers.
module evr_trig_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  evr_pkg::angle_t yaw,
  input  evr_pkg::angle_t pitch,
  input  evr_pkg::angle_t roll,
  output logic           busy,
  output evr_pkg::coef_t coef [evr_pkg::NUM_COEF]
);

  evr_pkg::trig_state_t state_r, state_nxt;
  logic [2:0] fn_r, fn_nxt;
  logic [3:0] step_r, step_nxt;

  logic [evr_pkg::U_W-1:0]    u2_r;
  logic [evr_pkg::POLY_W-1:0] p_r;
  evr_pkg::coef_t trig_r [evr_pkg::NUM_TRIG];
  evr_pkg::coef_t prod_r [evr_pkg::NUM_PROD];
  evr_pkg::coef_t coef_r [evr_pkg::NUM_COEF];

  evr_pkg::angle_t ang_sel, ang;
  logic [14:0] rr;
  logic        full;
  logic [evr_pkg::U_W-1:0]     u;
  logic [evr_pkg::U_W-1:0]     mul_a;
  logic [evr_pkg::POLY_W-1:0]  mul_b;
  logic [evr_pkg::MUL_W-1:0]   mul;
  logic [evr_pkg::POLY_W-1:0]  mshift;
  logic [evr_pkg::POLY_W+1:0]  vsum, vsh;
  evr_pkg::coef_t mag, trig_val;
  evr_pkg::coef_t op_a, op_b;
  logic trig_we, poly_we, u2_we, prod_we, coef_we;
  logic [evr_pkg::POLY_W-1:0] p_nxt;

  // Quadrant folding of the selected angle.
  always_comb begin
    unique case (fn_r[2:1])
      2'd0:    ang_sel = yaw;
      2'd1:    ang_sel = pitch;
      default: ang_sel = roll;
    endcase
    ang  = ang_sel + (fn_r[0] ? evr_pkg::ANGLE_W'(evr_pkg::QUARTER) : '0);
    rr   = ang[14] ? 15'(15'(evr_pkg::QUARTER) - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
    full = rr[14];
    u    = {rr[13:0], 16'd0};
  end

  // Shared polynomial multiplier: u*u first, then Horner steps, then u*p.
  always_comb begin
    mul_a  = (step_r == 4'd0 || step_r == 4'd7) ? u : u2_r;
    mul_b  = (step_r == 4'd0) ? {1'b0, u} : p_r;
    mul    = evr_pkg::MUL_W'(mul_a) * evr_pkg::MUL_W'(mul_b);
    mshift = mul[evr_pkg::MUL_W-1:30];
    vsum   = {2'b00, mshift} + evr_pkg::TRIG_HALF;
    vsh    = vsum >> evr_pkg::TRIG_SH;
    if (full || vsh > evr_pkg::ONE_U) begin
      mag = evr_pkg::COEF_ONE;
    end else begin
      mag = vsh[evr_pkg::COEF_W-1:0];
    end
    trig_val = ang[15] ? -mag : mag;
    p_nxt    = (step_r == 4'd0) ? evr_pkg::poly_coef(3'd6)
                                : evr_pkg::poly_coef(3'(4'd6 - step_r)) - mshift;
  end

  // Operand schedule of the matrix products.
  always_comb begin
    unique case (step_r)
      4'd0:    begin op_a = trig_r[1]; op_b = trig_r[2]; end
      4'd1:    begin op_a = trig_r[0]; op_b = trig_r[2]; end
      4'd2:    begin op_a = trig_r[1]; op_b = trig_r[3]; end
      4'd3:    begin op_a = prod_r[0]; op_b = trig_r[4]; end
      4'd4:    begin op_a = trig_r[0]; op_b = trig_r[5]; end
      4'd5:    begin op_a = prod_r[0]; op_b = trig_r[5]; end
      4'd6:    begin op_a = trig_r[0]; op_b = trig_r[4]; end
      4'd7:    begin op_a = trig_r[0]; op_b = trig_r[3]; end
      4'd8:    begin op_a = prod_r[1]; op_b = trig_r[4]; end
      4'd9:    begin op_a = trig_r[1]; op_b = trig_r[5]; end
      4'd10:   begin op_a = prod_r[1]; op_b = trig_r[5]; end
      4'd11:   begin op_a = trig_r[1]; op_b = trig_r[4]; end
      4'd12:   begin op_a = trig_r[3]; op_b = trig_r[4]; end
      default: begin op_a = trig_r[3]; op_b = trig_r[5]; end
    endcase
  end

  // Sequencer. Any angle write starts the build over from the first sine, so
  // the finished matrix always reflects the latest angles.
  always_comb begin
    state_nxt = state_r;
    fn_nxt    = fn_r;
    step_nxt  = step_r;
    trig_we   = 1'b0;
    poly_we   = 1'b0;
    u2_we     = 1'b0;
    prod_we   = 1'b0;
    coef_we   = 1'b0;
    if (start) begin
      state_nxt = evr_pkg::TRIG_POLY;
      fn_nxt    = '0;
      step_nxt  = '0;
    end else begin
      unique case (state_r)
        evr_pkg::TRIG_IDLE: ;
        evr_pkg::TRIG_POLY: begin
          if (full || step_r == 4'd7) begin
            trig_we  = 1'b1;
            step_nxt = '0;
            fn_nxt   = fn_r + 3'd1;
            if (fn_r == 3'(evr_pkg::NUM_TRIG - 1)) begin
              state_nxt = evr_pkg::TRIG_PROD;
            end
          end else begin
            poly_we  = 1'b1;
            u2_we    = (step_r == 4'd0);
            step_nxt = step_r + 4'd1;
          end
        end
        evr_pkg::TRIG_PROD: begin
          prod_we  = 1'b1;
          step_nxt = step_r + 4'd1;
          if (step_r == 4'(evr_pkg::NUM_PROD - 1)) begin
            state_nxt = evr_pkg::TRIG_COMBINE;
            step_nxt  = '0;
          end
        end
        evr_pkg::TRIG_COMBINE: begin
          coef_we   = 1'b1;
          state_nxt = evr_pkg::TRIG_IDLE;
        end
        default: state_nxt = evr_pkg::TRIG_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= evr_pkg::TRIG_IDLE;
      fn_r    <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fn_r    <= fn_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (u2_we) begin
      u2_r <= mshift[evr_pkg::U_W-1:0];
    end
    if (poly_we) begin
      p_r <= p_nxt;
    end
    if (trig_we) begin
      trig_r[fn_r] <= trig_val;
    end
    if (prod_we) begin
      prod_r[step_r] <= evr_pkg::qmul(op_a, op_b);
    end
  end

  // Coefficient store; identity after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < evr_pkg::NUM_COEF; i++) begin
        coef_r[i] <= (i % 4 == 0) ? evr_pkg::COEF_ONE : '0;
      end
    end else if (coef_we) begin
      coef_r[0] <= evr_pkg::clamp_coef((evr_pkg::COEF_W+1)'(prod_r[2]));
      coef_r[1] <= evr_pkg::clamp_coef((evr_pkg::COEF_W+1)'(prod_r[3])
                                       - (evr_pkg::COEF_W+1)'(prod_r[4]));
      coef_r[2] <= evr_pkg::clamp_coef((evr_pkg::COEF_W+1)'(prod_r[5])
                                       + (evr_pkg::COEF_W+1)'(prod_r[6]));
      coef_r[3] <= evr_pkg::clamp_coef((evr_pkg::COEF_W+1)'(prod_r[7]));
      coef_r[4] <= evr_pkg::clamp_coef((evr_pkg::COEF_W+1)'(prod_r[8])
                                       + (evr_pkg::COEF_W+1)'(prod_r[9]));
      coef_r[5] <= evr_pkg::clamp_coef((evr_pkg::COEF_W+1)'(prod_r[10])
                                       - (evr_pkg::COEF_W+1)'(prod_r[11]));
      coef_r[6] <= evr_pkg::clamp_coef(-(evr_pkg::COEF_W+1)'(trig_r[2]));
      coef_r[7] <= evr_pkg::clamp_coef((evr_pkg::COEF_W+1)'(prod_r[12]));
      coef_r[8] <= evr_pkg::clamp_coef((evr_pkg::COEF_W+1)'(prod_r[13]));
    end
  end

  assign busy = (state_r != evr_pkg::TRIG_IDLE);
  assign coef = coef_r;

endmodule

// ===== design/evr_lane.sv =====
// One matrix row: three products, then a rounded and saturated sum.
module evr_lane (
  input  logic               clk,
  input  evr_pkg::lane_ctl_t ctl,
  input  evr_pkg::coef_t     row [3],
  input  evr_pkg::coord_t    px,
  input  evr_pkg::coord_t    py,
  input  evr_pkg::coord_t    pz,
  output evr_pkg::out_t      result
);

  logic signed [evr_pkg::PROD_W-1:0] prod_r [3];
  logic signed [evr_pkg::ACC_W-1:0]  acc, rnd;
  logic signed [evr_pkg::QW-1:0]     q;
  evr_pkg::out_t result_r, result_nxt;

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      prod_r[0] <= evr_pkg::PROD_W'(row[0]) * evr_pkg::PROD_W'(px);
      prod_r[1] <= evr_pkg::PROD_W'(row[1]) * evr_pkg::PROD_W'(py);
      prod_r[2] <= evr_pkg::PROD_W'(row[2]) * evr_pkg::PROD_W'(pz);
    end
  end

  // Rounding half away from zero folds into one add with a carry correction.
  always_comb begin
    acc = evr_pkg::ACC_W'(prod_r[0]) + evr_pkg::ACC_W'(prod_r[1])
        + evr_pkg::ACC_W'(prod_r[2]);
    rnd = acc + evr_pkg::ACC_HALF - evr_pkg::ACC_W'({1'b0, acc[evr_pkg::ACC_W-1]});
    q   = rnd[evr_pkg::ACC_W-1:evr_pkg::COEF_FRACTION_BITS];
    if (q > evr_pkg::OUT_MAX_Q) begin
      result_nxt = evr_pkg::OUT_W'(evr_pkg::OUT_MAX_Q);
    end else if (q < evr_pkg::OUT_MIN_Q) begin
      result_nxt = evr_pkg::OUT_W'(evr_pkg::OUT_MIN_Q);
    end else begin
      result_nxt = q[evr_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_en) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

// ===== design/euler_vector_rotator.sv =====
// A point accepted into the product stage moves on to the result register, which drives the output.
// Throughput: one point per clock unless the output or a rebuild stalls; three row lanes in parallel.
// Writing an angle register rebuilds the matrix after the last write (polynomial
// steps on one shared multiplier, 14 products, one combine); input ready is low
// then. Reset (synchronous, rst_n low): angles zero, matrix identity,
// pipeline empty. Top level of the Z-Y-X Euler point rotator.
module euler_vector_rotator (
  input  logic                              clk,
  input  logic                              rst_n,
  evr_point_if.sink                         in_pt,
  evr_rot_if.source                         out_rot,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [evr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [evr_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [evr_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  // Angle registers. The register index is the word address; low address
  // bits are ignored, and the unused fourth slot reads zero and drops writes.
  evr_pkg::angle_t yaw_r, pitch_r, roll_r;
  evr_pkg::reg_idx_t reg_idx;
  logic cfg_wr, rebuild;

  assign reg_idx = evr_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign rebuild = cfg_wr && (reg_idx != evr_pkg::REG_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r   <= '0;
      pitch_r <= '0;
      roll_r  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        evr_pkg::REG_YAW:   yaw_r   <= pwdata[evr_pkg::ANGLE_W-1:0];
        evr_pkg::REG_PITCH: pitch_r <= pwdata[evr_pkg::ANGLE_W-1:0];
        evr_pkg::REG_ROLL:  roll_r  <= pwdata[evr_pkg::ANGLE_W-1:0];
        evr_pkg::REG_NONE:  ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      evr_pkg::REG_YAW:   prdata = evr_pkg::CFG_DATA_W'(yaw_r);
      evr_pkg::REG_PITCH: prdata = evr_pkg::CFG_DATA_W'(pitch_r);
      evr_pkg::REG_ROLL:  prdata = evr_pkg::CFG_DATA_W'(roll_r);
      evr_pkg::REG_NONE:  prdata = '0;
    endcase
  end

  // The matrix builder runs after any angle write; its coefficient store
  // stays fixed while points stream through.
  logic busy;
  evr_pkg::coef_t coef [evr_pkg::NUM_COEF];

  evr_trig_unit u_trig (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rebuild),
    .yaw   (yaw_r),
    .pitch (pitch_r),
    .roll  (roll_r),
    .busy  (busy),
    .coef  (coef)
  );

  // Two-stage pipeline with bubble collapse. Stage one holds the products,
  // stage two holds the finished result and is the output register, so a
  // new beat enters whenever stage one is empty or moving on and no rebuild runs.
  logic s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt;
  logic adv2, load1, load2;
  evr_pkg::lane_ctl_t ctl;

  assign adv2         = !s2_v_r || out_rot.ready;
  assign in_pt.ready  = (!s1_v_r || adv2) && !busy;
  assign load1        = in_pt.valid && in_pt.ready;
  assign load2        = s1_v_r && adv2;
  assign s1_v_nxt     = load1 || (s1_v_r && !adv2);
  assign s2_v_nxt     = load2 || (s2_v_r && !out_rot.ready);
  assign ctl.s1_en    = load1;
  assign ctl.s2_en    = load2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // One lane per matrix row; every lane sees the whole point.
  evr_pkg::out_t lane_out [3];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    evr_pkg::coef_t row [3];
    assign row[0] = coef[3*l];
    assign row[1] = coef[3*l+1];
    assign row[2] = coef[3*l+2];

    evr_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .row    (row),
      .px     (in_pt.point_x),
      .py     (in_pt.point_y),
      .pz     (in_pt.point_z),
      .result (lane_out[l])
    );
  end

  // The three lane results form one output beat.
  assign out_rot.valid     = s2_v_r;
  assign out_rot.rotated_x = lane_out[0];
  assign out_rot.rotated_y = lane_out[1];
  assign out_rot.rotated_z = lane_out[2];

endmodule

// ===== design/evr_checker.sv =====
// Port-level checks for the rotator and their binding to the top level.
module evr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [evr_pkg::CFG_ADDR_W-1:0] paddr
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // An angle write starts a matrix rebuild, which blocks new points.
  a_rebuild_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && (paddr[3:2] != evr_pkg::REG_NONE) |=> !in_ready)
    else $error("point accepted during matrix rebuild");

endmodule

bind euler_vector_rotator evr_checker u_evr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_pt.ready),
  .out_valid (out_rot.valid),
  .out_ready (out_rot.ready),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr)
);
